### hdl/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_pkg
// shared types and constants for the rgb to hsv pixel converter
// ============================================================================
package rgbhsv_pkg;

    localparam int CH_W        = 8;
    localparam int HUE_W       = 15;
    localparam int SAT_W       = 16;
    localparam int BRIGHT_W    = 16;
    localparam int PIXEL_W     = 32;

    // divider datapath
    localparam int DIV_N_W     = 24;
    localparam int DIV_Q_W     = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // hue in degrees times 64
    localparam logic [HUE_W-1:0] HUE_SECTOR    = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_BASE_RED  = 15'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_GRN  = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BASE_BLU  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  d;
        logic [CH_W-1:0]  num;
        logic [HUE_W-1:0] base;
        logic             neg;
        logic             gray;
    } rgbhsv_item_t;

    // per stage load enables for a divider lane
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } rgbhsv_div_ctl_t;

endpackage

### hdl/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// ============================================================================
// rgb_to_hsv_pixel
// converts a bgra8 pixel word into fixed point hue, saturation and brightness
// ============================================================================
// input channel: in_valid / in_stall with pixel_word; a transaction is taken
// at a rising edge with in_valid high and in_stall low. alpha is ignored.
// output channel: out_valid / out_stall with hue, saturation and brightness;
// hue is degrees times 64, saturation and brightness are scaled to 65535.
// from input transaction to output valid a pixel passes one front register,
// the queue and five back stages (reciprocal lookup, estimate multiply,
// back multiply, correction, output).
// throughput is one pixel per clock while the receiver does not stall; each
// divide is a reciprocal table read and two pipelined multiplies, so no stage iterates.
// when the receiver stalls, the back stages fill, then the queue of
// QUEUE_DEPTH entries, then the front, and only then in_stall rises.
// reset clears all valid bits and the queue; no result is shown afterwards
// until a new pixel has gone through.
// ============================================================================
module rgb_to_hsv_pixel
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rgbhsv_pkg::PIXEL_W-1:0]        pixel_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rgbhsv_pkg::HUE_W-1:0]          hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]          saturation,
    output logic [rgbhsv_pkg::BRIGHT_W-1:0]       brightness
);

    logic                     f_valid;
    logic                     f_ready;
    rgbhsv_pkg::rgbhsv_item_t f_item;
    logic                     q_valid;
    logic                     q_ready;
    rgbhsv_pkg::rgbhsv_item_t q_item;

    rgbhsv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_word (pixel_word),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    rgbhsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    rgbhsv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

### hdl/rgbhsv_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_front
// accepts pixel transactions, finds max and min and classifies the hue sector
// ============================================================================
module rgbhsv_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rgbhsv_pkg::PIXEL_W-1:0]        pixel_word,
    output logic                                  item_valid,
    input  logic                                  item_ready,
    output rgbhsv_pkg::rgbhsv_item_t              item
);

    logic [rgbhsv_pkg::CH_W-1:0] r;
    logic [rgbhsv_pkg::CH_W-1:0] g;
    logic [rgbhsv_pkg::CH_W-1:0] b;
    logic [rgbhsv_pkg::CH_W-1:0] mx;
    logic [rgbhsv_pkg::CH_W-1:0] mn;
    rgbhsv_pkg::rgbhsv_item_t    cls;
    rgbhsv_pkg::rgbhsv_item_t    item_reg;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        load;

    assign b = pixel_word[7:0];
    assign g = pixel_word[15:8];
    assign r = pixel_word[23:16];

    always_comb
    begin
        mx = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
    end

    // ties: red before green before blue
    always_comb
    begin
        cls.mx   = mx;
        cls.d    = mx - mn;
        cls.gray = (mx == mn);
        priority if (mx == r)
        begin
            cls.neg  = (g < b);
            cls.num  = (g < b) ? (b - g) : (g - b);
            cls.base = (g < b) ? rgbhsv_pkg::HUE_FULL_TURN : rgbhsv_pkg::HUE_BASE_RED;
        end
        else if (mx == g)
        begin
            cls.neg  = (b < r);
            cls.num  = (b < r) ? (r - b) : (b - r);
            cls.base = rgbhsv_pkg::HUE_BASE_GRN;
        end
        else
        begin
            cls.neg  = (r < g);
            cls.num  = (r < g) ? (g - r) : (r - g);
            cls.base = rgbhsv_pkg::HUE_BASE_BLU;
        end
    end

    assign load       = !valid_reg || item_ready;
    assign in_stall   = !load;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= cls;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/rgbhsv_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_queue
// small fifo of classified pixels between front and back
// ============================================================================
module rgbhsv_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_valid,
    output logic                     wr_ready,
    input  rgbhsv_pkg::rgbhsv_item_t wr_item,
    output logic                     rd_valid,
    input  logic                     rd_ready,
    output rgbhsv_pkg::rgbhsv_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgbhsv_pkg::rgbhsv_item_t mem [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [PTR_W-1:0]         wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic [PTR_W-1:0]         rd_ptr_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     push;
    logic                     pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/rgbhsv_div.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_div
// three stage reciprocal divider lane: estimate, back multiply, correct
// ============================================================================
module rgbhsv_div
(
    input  logic                                  clk,
    input  rgbhsv_pkg::rgbhsv_div_ctl_t           ctl,
    input  logic [rgbhsv_pkg::DIV_N_W-1:0]        n,
    input  logic [rgbhsv_pkg::CH_W-1:0]           den,
    input  logic [rgbhsv_pkg::RECIP_W-1:0]        recip,
    output logic [rgbhsv_pkg::DIV_Q_W-1:0]        q,
    output logic                                  rem_nz
);

    localparam int MUL_W = rgbhsv_pkg::DIV_N_W + rgbhsv_pkg::RECIP_W;

    logic [MUL_W-1:0]                    mul_full;
    logic [rgbhsv_pkg::DIV_Q_W-1:0]      q2_reg;
    logic [rgbhsv_pkg::DIV_N_W-1:0]      n2_reg;
    logic [rgbhsv_pkg::CH_W-1:0]         den2_reg;
    logic [rgbhsv_pkg::DIV_N_W-1:0]      prod3_reg;
    logic [rgbhsv_pkg::DIV_Q_W-1:0]      q3_reg;
    logic [rgbhsv_pkg::DIV_N_W-1:0]      n3_reg;
    logic [rgbhsv_pkg::CH_W-1:0]         den3_reg;
    logic [rgbhsv_pkg::DIV_N_W-1:0]      rem;
    logic                                over;
    logic [rgbhsv_pkg::DIV_Q_W-1:0]      q4_reg;
    logic                                nz4_reg;

    // estimate is the true quotient or one below it
    assign mul_full = MUL_W'(n) * MUL_W'(recip);
    assign rem      = n3_reg - prod3_reg;
    assign over     = (rem >= rgbhsv_pkg::DIV_N_W'(den3_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            q2_reg   <= mul_full[rgbhsv_pkg::RECIP_SHIFT +: rgbhsv_pkg::DIV_Q_W];
            n2_reg   <= n;
            den2_reg <= den;
        end
        if (ctl.ld3)
        begin
            prod3_reg <= rgbhsv_pkg::DIV_N_W'(q2_reg) * rgbhsv_pkg::DIV_N_W'(den2_reg);
            q3_reg    <= q2_reg;
            n3_reg    <= n2_reg;
            den3_reg  <= den2_reg;
        end
        if (ctl.ld4)
        begin
            q4_reg  <= over ? q3_reg + 1'b1 : q3_reg;
            nz4_reg <= over ? (rem != rgbhsv_pkg::DIV_N_W'(den3_reg)) : (rem != '0);
        end
    end

    assign q      = q4_reg;
    assign rem_nz = nz4_reg;

endmodule

### hdl/rgbhsv_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_back
// five stage back end: reciprocal lookup, two divider lanes, output register
// ============================================================================
module rgbhsv_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  rgbhsv_pkg::rgbhsv_item_t              item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rgbhsv_pkg::HUE_W-1:0]          hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]          saturation,
    output logic [rgbhsv_pkg::BRIGHT_W-1:0]       brightness
);

    localparam int NW     = rgbhsv_pkg::DIV_N_W;
    localparam int TAB_N  = 2 ** rgbhsv_pkg::CH_W;

    logic [rgbhsv_pkg::RECIP_W-1:0] recip_tab [TAB_N];

    for (genvar i = 0; i < TAB_N; i++)
    begin : g_recip
        if (i == 0)
        begin : g_zero
            assign recip_tab[i] = '0;
        end
        else
        begin : g_val
            localparam logic [rgbhsv_pkg::RECIP_W-1:0] RV =
                rgbhsv_pkg::RECIP_W'((64'd1 << rgbhsv_pkg::RECIP_SHIFT) / i);
            assign recip_tab[i] = RV;
        end
    end

    logic [4:0] v_reg;
    logic [4:0] v_next;
    logic [4:0] rdy;

    rgbhsv_pkg::rgbhsv_item_t       it_reg [4];
    logic [NW-1:0]                  n_sat_reg;
    logic [NW-1:0]                  n_hue_reg;
    logic [rgbhsv_pkg::RECIP_W-1:0] r_mx_reg;
    logic [rgbhsv_pkg::RECIP_W-1:0] r_d_reg;
    rgbhsv_pkg::rgbhsv_div_ctl_t    ctl;
    logic [rgbhsv_pkg::DIV_Q_W-1:0] q_sat;
    logic [rgbhsv_pkg::DIV_Q_W-1:0] q_hue;
    logic                           sat_nz;
    logic                           hue_nz;
    logic [rgbhsv_pkg::DIV_Q_W-1:0] hue_ceil;
    logic [rgbhsv_pkg::DIV_Q_W-1:0] hue_raw;
    logic [rgbhsv_pkg::HUE_W-1:0]   hue_reg;
    logic [rgbhsv_pkg::SAT_W-1:0]   sat_reg;
    logic [rgbhsv_pkg::BRIGHT_W-1:0] bright_reg;

    // a stage loads when it is empty or its successor moves
    assign rdy[4] = !v_reg[4] || !out_stall;
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];

    assign item_ready = rdy[0];
    assign ctl.ld2    = rdy[1];
    assign ctl.ld3    = rdy[2];
    assign ctl.ld4    = rdy[3];

    always_comb
    begin
        v_next[0] = rdy[0] ? item_valid : v_reg[0];
        for (int s = 1; s < 5; s++)
        begin
            v_next[s] = rdy[s] ? v_reg[s-1] : v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            it_reg[0] <= item;
            n_sat_reg <= NW'({item.d, 16'h0000}) - NW'(item.d);
            n_hue_reg <= NW'({item.num, 12'h000}) - NW'({item.num, 8'h00});
            r_mx_reg  <= recip_tab[item.mx];
            r_d_reg   <= recip_tab[item.d];
        end
        for (int s = 1; s < 4; s++)
        begin
            if (rdy[s])
            begin
                it_reg[s] <= it_reg[s-1];
            end
        end
    end

    rgbhsv_div u_div_sat
    (
        .clk    (clk),
        .ctl    (ctl),
        .n      (n_sat_reg),
        .den    (it_reg[0].mx),
        .recip  (r_mx_reg),
        .q      (q_sat),
        .rem_nz (sat_nz)
    );

    rgbhsv_div u_div_hue
    (
        .clk    (clk),
        .ctl    (ctl),
        .n      (n_hue_reg),
        .den    (it_reg[0].d),
        .recip  (r_d_reg),
        .q      (q_hue),
        .rem_nz (hue_nz)
    );

    // negative offsets round toward minus infinity
    assign hue_ceil = q_hue + rgbhsv_pkg::DIV_Q_W'(hue_nz);
    assign hue_raw  = it_reg[3].neg
                    ? rgbhsv_pkg::DIV_Q_W'(it_reg[3].base) - hue_ceil
                    : rgbhsv_pkg::DIV_Q_W'(it_reg[3].base) + q_hue;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            hue_reg    <= it_reg[3].gray ? '0 : hue_raw[rgbhsv_pkg::HUE_W-1:0];
            sat_reg    <= it_reg[3].gray ? '0 : q_sat;
            bright_reg <= {it_reg[3].mx, it_reg[3].mx};
        end
    end

    assign out_valid  = v_reg[4];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

### hdl/rgbhsv_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rgbhsv_checker
// port level checks on the converter output channel
// ============================================================================
module rgbhsv_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [rgbhsv_pkg::HUE_W-1:0]          hue,
    input logic [rgbhsv_pkg::SAT_W-1:0]          saturation,
    input logic [rgbhsv_pkg::BRIGHT_W-1:0]       brightness
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hue)
            && $stable(saturation) && $stable(brightness))
        else $error("output transaction changed while stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < rgbhsv_pkg::HUE_FULL_TURN)
        else $error("hue out of range");

    // gray pixels carry no hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == '0 |-> hue == '0)
        else $error("zero saturation with nonzero hue");

    a_bright_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> brightness[15:8] == brightness[7:0])
        else $error("brightness not a multiple of 257");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
);
